// ===== rtl/lops_pkg.sv =====
`default_nettype none
package lops_pkg;

  localparam int NAME_CAPACITY        = 64;
  localparam int PATH_CAPACITY        = 256;
  localparam int DEVICE_PATH_CAPACITY = 512;
  localparam int OPTION_MAX_BYTES     = 4096;

  localparam int BP_W = $clog2(OPTION_MAX_BYTES + 1);
  localparam int NC_W = $clog2(NAME_CAPACITY);
  localparam int LC_W = $clog2(PATH_CAPACITY);
  localparam int FB_LEN = (NAME_CAPACITY - 1 < 9) ? NAME_CAPACITY - 1 : 9;
  localparam int FB_W = 4;

  localparam logic [7:0] NODE_MEDIA   = 8'h04;
  localparam logic [7:0] SUB_FILEPATH = 8'h04;
  localparam logic [7:0] NODE_END     = 8'h7F;
  localparam logic [7:0] SUB_END_ALL  = 8'hFF;
  localparam logic [7:0] SUB_END_INST = 8'h01;
  localparam logic [15:0] CHAR_LOW    = 16'h0020;
  localparam logic [15:0] CHAR_HIGH   = 16'h007E;
  localparam logic [15:0] CHAR_QMARK  = 16'h003F;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DESC   = 2'd1,
    PH_PATH   = 2'd2,
    PH_IDLE   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DESC   = 2'd0,
    KIND_LOADER = 2'd1,
    KIND_PATH   = 2'd2,
    KIND_STATUS = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_INACTIVE  = 3'd2,
    ST_BAD_SIZE  = 3'd3,
    ST_LOAD_ERR  = 3'd4
  } status_e;

  function automatic logic [15:0] hex_char(input logic [3:0] v);
    hex_char = (v < 4'd10) ? (16'h0030 + 16'(v)) : (16'h0037 + 16'(v));
  endfunction

  // Fallback name "BOOT xxxx", upper-case hex of the option number.
  function automatic logic [15:0] fb_char(input logic [FB_W-1:0] idx,
                                          input logic [15:0] num);
    logic [15:0] c;
    c = 16'h0000;
    unique case (idx)
      4'd0: c = 16'h0042;
      4'd1: c = 16'h004F;
      4'd2: c = 16'h004F;
      4'd3: c = 16'h0054;
      4'd4: c = 16'h0020;
      4'd5: c = hex_char(num[15:12]);
      4'd6: c = hex_char(num[11:8]);
      4'd7: c = hex_char(num[7:4]);
      4'd8: c = hex_char(num[3:0]);
      default: c = 16'h0000;
    endcase
    fb_char = c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/load_option_stream_parser_unit.sv =====
`default_nettype none
// Load option stream parser. Takes one load option byte per transfer (last
// byte marked), checks the header, turns the UTF-16 description into
// printable ASCII ('?' for other codes, "BOOT xxxx" when empty), walks the
// device path node by node, and emits each device path byte up to the first
// path error, the first file-path node's characters, and finally one status
// result. Each byte is parsed combinationally into a result register holding
// up to the fallback name, one description or device path result, one loader
// char and the status. The result register drains one result per cycle while
// the output is not stalled, so a byte that yields at most one result
// sustains one byte per cycle; intake of the next byte stalls until the last
// result of the previous byte transfers.
module load_option_stream_parser_unit import lops_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [15:0] boot_number_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [15:0]      value_o,
  output logic [2:0]       status_o,
  output logic             done_res_o
);

  // Parser state
  logic [BP_W-1:0] bp_q, bp_d;
  phase_e          ph_q, ph_d;
  logic [7:0]      held_q, held_d;
  logic [15:0]     psize_q, psize_d;
  logic [NC_W-1:0] nc_q, nc_d;
  logic [15:0]     poff_q, poff_d;
  logic [31:0]     nf_q, nf_d;
  logic [15:0]     nrem_q, nrem_d;
  logic [LC_W-1:0] lc_q, lc_d;
  logic [2:0]      ferr_q, ferr_d;
  logic [15:0]     num_q, num_d;
  logic [15:0]     nstart_q, nstart_d;
  logic [1:0]      hdr_q, hdr_d;
  logic            term_q, term_d, perr_q, perr_d, endall_q, endall_d;
  logic            fnode_q, fnode_d, fterm_q, fterm_d, over_q, over_d;

  // Result register
  logic [FB_W-1:0] fb_left_q, fb_left_d;
  logic [15:0]     fb_num_q, fb_num_d;
  logic            a_vld_q, a_vld_d, l_vld_q, l_vld_d, s_vld_q, s_vld_d;
  kind_e           a_kind_q, a_kind_d;
  logic [15:0]     a_val_q, a_val_d, l_val_q, l_val_d;
  logic [2:0]      st_q, st_d;

  // Results of the byte being accepted
  logic            e_fb, e_a, e_l, e_s;
  kind_e           e_akind;
  logic [15:0]     e_aval, e_lval;
  logic [2:0]      e_st;

  logic            in_xfer, out_xfer, busy, final_piece;
  logic [4:0]      pieces;

  assign busy   = (fb_left_q != '0) | a_vld_q | l_vld_q | s_vld_q;
  assign pieces = 5'(fb_left_q) + 5'(a_vld_q) + 5'(l_vld_q) + 5'(s_vld_q);
  assign final_piece = (pieces == 5'd1);
  assign out_valid_o = busy;
  assign out_xfer    = out_valid_o & ~out_stall_i;
  assign in_stall_o  = busy & ~(out_xfer & final_piece);
  assign in_xfer     = in_valid_i & ~in_stall_o;

  // Present the oldest pending result: fallback name, then device path or
  // description result, then loader char, then status.
  always_comb begin
    kind_o     = KIND_STATUS;
    value_o    = '0;
    status_o   = st_q;
    done_res_o = 1'b1;
    if (fb_left_q != '0) begin
      kind_o     = KIND_DESC;
      value_o    = fb_char(FB_W'(FB_LEN) - fb_left_q, fb_num_q);
      status_o   = ST_OK;
      done_res_o = 1'b0;
    end else if (a_vld_q) begin
      kind_o     = a_kind_q;
      value_o    = a_val_q;
      status_o   = ST_OK;
      done_res_o = 1'b0;
    end else if (l_vld_q) begin
      kind_o     = KIND_LOADER;
      value_o    = l_val_q;
      status_o   = ST_OK;
      done_res_o = 1'b0;
    end
  end

  // Byte parser
  always_comb begin
    logic [7:0]  b;
    logic [15:0] ch, len;
    logic [7:0]  ntype, nsub;
    bp_d = bp_q; ph_d = ph_q; held_d = held_q; psize_d = psize_q;
    nc_d = nc_q; poff_d = poff_q; nf_d = nf_q; nrem_d = nrem_q;
    lc_d = lc_q; ferr_d = ferr_q; num_d = num_q; nstart_d = nstart_q;
    hdr_d = hdr_q; term_d = term_q; perr_d = perr_q; endall_d = endall_q;
    fnode_d = fnode_q; fterm_d = fterm_q; over_d = over_q;
    e_fb = 1'b0; e_a = 1'b0; e_l = 1'b0; e_s = 1'b0;
    e_akind = KIND_DESC; e_aval = '0; e_lval = '0; e_st = ST_OK;
    b = data_byte_i;
    ch = '0; len = '0; ntype = '0; nsub = '0;

    if (in_xfer) begin
      if (bp_q >= BP_W'(OPTION_MAX_BYTES)) begin
        over_d = 1'b1;
      end else begin
        bp_d = bp_q + 1'b1;
        unique case (ph_q)
          PH_HEADER: begin
            if (bp_q == '0) begin
              num_d = boot_number_i;
              if (!b[0]) ferr_d = ST_INACTIVE;
            end else if (bp_q == BP_W'(4)) begin
              psize_d = {8'h00, b};
            end else if (bp_q == BP_W'(5)) begin
              psize_d = {b, psize_q[7:0]};
              if (ferr_d == ST_OK && (psize_d < 16'd4 ||
                  psize_d > 16'(DEVICE_PATH_CAPACITY)))
                ferr_d = ST_BAD_SIZE;
              ph_d = (ferr_d != ST_OK) ? PH_IDLE : PH_DESC;
            end
          end
          PH_DESC: begin
            if (!bp_q[0]) begin
              held_d = b;
            end else begin
              ch = {b, held_q};
              if (ch == '0) begin
                term_d = 1'b1;
                if (nc_q == '0) e_fb = 1'b1;
                ph_d = PH_PATH;
                poff_d = '0; hdr_d = '0; nrem_d = '0;
              end else if (nc_q < NC_W'(NAME_CAPACITY - 1)) begin
                e_a = 1'b1;
                e_akind = KIND_DESC;
                e_aval = (ch >= CHAR_LOW && ch <= CHAR_HIGH) ? ch : CHAR_QMARK;
                nc_d = nc_q + 1'b1;
              end
            end
          end
          PH_PATH: begin
            if (!perr_q) begin
              e_a = 1'b1;
              e_akind = KIND_PATH;
              e_aval = {8'h00, b};
              if (hdr_q != '0 || nrem_q == '0) begin
                if (hdr_q == '0) begin
                  nstart_d = poff_q;
                  nf_d = '0;
                  if (psize_q - poff_q < 16'd4) perr_d = 1'b1;
                end
                if (!perr_d) begin
                  nf_d[8*hdr_q +: 8] = b;
                  hdr_d = hdr_q + 1'b1;
                  if (hdr_q == 2'd3) begin
                    // Node header complete: check it.
                    ntype = nf_d[7:0];
                    nsub  = nf_d[15:8];
                    len   = nf_d[31:16];
                    fnode_d = 1'b0;
                    fterm_d = 1'b0;
                    if (len < 16'd4 || len > psize_q - nstart_d) begin
                      perr_d = 1'b1;
                    end else if (ntype == NODE_MEDIA && nsub == SUB_FILEPATH &&
                                 lc_q == '0 && (len[0] || len == 16'd4)) begin
                      perr_d = 1'b1;
                    end else begin
                      if (ntype == NODE_MEDIA && nsub == SUB_FILEPATH && lc_q == '0)
                        fnode_d = 1'b1;
                      if (ntype == NODE_END && (len != 16'd4 ||
                          (nsub != SUB_END_ALL && nsub != SUB_END_INST))) begin
                        perr_d = 1'b1;
                      end else begin
                        if (ntype == NODE_END && nsub == SUB_END_ALL) begin
                          endall_d = 1'b1;
                          if (17'(nstart_d) + 17'd4 != 17'(psize_q)) perr_d = 1'b1;
                        end
                        if (!perr_d) nrem_d = len - 16'd4;
                      end
                    end
                  end
                end
              end else begin
                len = nf_q[31:16];
                nrem_d = nrem_q - 1'b1;
                if (fnode_q && !fterm_q) begin
                  if (len[0] == nrem_q[0]) begin
                    held_d = b;
                  end else begin
                    ch = {b, held_q};
                    if (ch == '0) begin
                      fterm_d = 1'b1;
                    end else if (lc_q < LC_W'(PATH_CAPACITY - 1)) begin
                      e_l = 1'b1;
                      e_lval = ch;
                      lc_d = lc_q + 1'b1;
                    end
                  end
                  if (nrem_d == '0 && !fterm_d) perr_d = 1'b1;
                end
              end
            end
            poff_d = poff_q + 1'b1;
            if (poff_d >= psize_q) ph_d = PH_IDLE;
          end
          PH_IDLE: begin
          end
          default: begin
          end
        endcase
      end

      if (last_byte_i) begin
        e_s = 1'b1;
        if (over_d)                        e_st = ST_BAD_SIZE;
        else if (bp_d < BP_W'(8))          e_st = ST_TOO_SHORT;
        else if (ferr_d != ST_OK)          e_st = ferr_d;
        else if (!term_d)                  e_st = ST_LOAD_ERR;
        else if (poff_d < psize_d)         e_st = ST_BAD_SIZE;
        else if (perr_d || !endall_d)      e_st = ST_LOAD_ERR;
        else                               e_st = ST_OK;
        // Drop all option state for the next option.
        bp_d = '0; ph_d = PH_HEADER; held_d = '0; psize_d = '0; nc_d = '0;
        poff_d = '0; nf_d = '0; nrem_d = '0; lc_d = '0; ferr_d = ST_OK;
        num_d = '0; nstart_d = '0; hdr_d = '0; term_d = 1'b0; perr_d = 1'b0;
        endall_d = 1'b0; fnode_d = 1'b0; fterm_d = 1'b0; over_d = 1'b0;
      end
    end
  end

  // Result register: load on intake, otherwise retire the presented piece.
  always_comb begin
    fb_left_d = fb_left_q; fb_num_d = fb_num_q;
    a_vld_d = a_vld_q; l_vld_d = l_vld_q; s_vld_d = s_vld_q;
    a_kind_d = a_kind_q; a_val_d = a_val_q; l_val_d = l_val_q; st_d = st_q;
    if (in_xfer) begin
      fb_left_d = e_fb ? FB_W'(FB_LEN) : '0;
      fb_num_d  = num_q;
      a_vld_d = e_a; a_kind_d = e_akind; a_val_d = e_aval;
      l_vld_d = e_l; l_val_d = e_lval;
      s_vld_d = e_s; st_d = e_st;
    end else if (out_xfer) begin
      if (fb_left_q != '0) fb_left_d = fb_left_q - 1'b1;
      else if (a_vld_q)    a_vld_d = 1'b0;
      else if (l_vld_q)    l_vld_d = 1'b0;
      else                 s_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_q <= '0; ph_q <= PH_HEADER; held_q <= '0; psize_q <= '0; nc_q <= '0;
      poff_q <= '0; nf_q <= '0; nrem_q <= '0; lc_q <= '0; ferr_q <= ST_OK;
      num_q <= '0; nstart_q <= '0; hdr_q <= '0; term_q <= 1'b0; perr_q <= 1'b0;
      endall_q <= 1'b0; fnode_q <= 1'b0; fterm_q <= 1'b0; over_q <= 1'b0;
      fb_left_q <= '0; a_vld_q <= 1'b0; l_vld_q <= 1'b0; s_vld_q <= 1'b0;
    end else begin
      bp_q <= bp_d; ph_q <= ph_d; held_q <= held_d; psize_q <= psize_d;
      nc_q <= nc_d; poff_q <= poff_d; nf_q <= nf_d; nrem_q <= nrem_d;
      lc_q <= lc_d; ferr_q <= ferr_d; num_q <= num_d; nstart_q <= nstart_d;
      hdr_q <= hdr_d; term_q <= term_d; perr_q <= perr_d; endall_q <= endall_d;
      fnode_q <= fnode_d; fterm_q <= fterm_d; over_q <= over_d;
      fb_left_q <= fb_left_d; a_vld_q <= a_vld_d; l_vld_q <= l_vld_d;
      s_vld_q <= s_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fb_num_q <= fb_num_d; a_kind_q <= a_kind_d; a_val_q <= a_val_d;
    l_val_q <= l_val_d; st_q <= st_d;
  end

  a_intake_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && busy |-> out_xfer && final_piece)
    else $error("intake while results still pending");
  a_fb_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fb_left_q <= FB_W'(FB_LEN))
    else $error("fallback counter out of range");
  a_done_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (done_res_o == (kind_o == KIND_STATUS)))
    else $error("done flag not on status result");
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && last_byte_i |=> bp_q == '0 && ph_q == PH_HEADER)
    else $error("option state not cleared after last byte");

endmodule
`default_nettype wire

// ===== tb/tb_load_option_stream_parser_unit.sv =====
`timescale 1ns / 100ps
module tb_load_option_stream_parser_unit;
  import lops_pkg::*;

  // Parse flags of the predictor
  localparam int unsigned FL_TERM       = 32'h01;
  localparam int unsigned FL_PATH_ERR   = 32'h02;
  localparam int unsigned FL_END_ENTIRE = 32'h04;
  localparam int unsigned FL_FILE_NODE  = 32'h08;
  localparam int unsigned FL_FILE_TERM  = 32'h10;
  localparam int unsigned FL_OVER       = 32'h20;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] value;
    status_e     status;
    logic        done;
  } parse_res_t;

  // One row of the directed table; typed rows carry their status by hand
  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] num;
    logic        last;
    logic        typed;
    status_e     status;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic [15:0] boot_number_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  kind_o;
  logic [15:0] value_o;
  logic [2:0]  status_o;
  logic        done_res_o;

  load_option_stream_parser_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .boot_number_i(boot_number_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .value_o      (value_o),
    .status_o     (status_o),
    .done_res_o   (done_res_o)
  );

  // Expected results of the parse, oldest first
  parse_res_t  parse_q[$];
  int          fail_cnt = 0;
  int          cycle_cnt = 0;
  bit          quiet = 0;      // no idling on either side
  bit          hold_req = 0;   // ask the receiver for one long hold-off
  bit          hold_done = 0;

  // Predictor state, one option at a time
  int unsigned opt_pos, dp_size, name_cnt, dp_off, node_left, loader_cnt;
  int unsigned flags, node_base, hdr_cnt;
  phase_e      ph;
  status_e     first_err;
  logic [7:0]  low_byte;
  logic [31:0] node_hdr;
  logic [15:0] saved_num;

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // Give up if the run hangs
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("load_option_stream_parser_unit: mismatch");
    $finish;
  end

  task automatic clear_option();
    opt_pos = 0; ph = PH_HEADER; low_byte = '0; dp_size = 0; name_cnt = 0;
    dp_off = 0; node_hdr = '0; node_left = 0; loader_cnt = 0; flags = 0;
    first_err = ST_OK; saved_num = '0; node_base = 0; hdr_cnt = 0;
  endtask

  task automatic push_res(kind_e k, logic [15:0] v, status_e s, logic d);
    parse_res_t r;
    r.kind = k; r.value = v; r.status = s; r.done = d;
    parse_q.push_back(r);
  endtask

  function automatic logic [15:0] hex_digit(logic [3:0] v);
    return (v < 10) ? 16'(8'h30 + v) : 16'(8'h41 + v - 10);
  endfunction

  // Check the four header bytes of a device path node
  task automatic node_header_done();
    int unsigned ntype, nsub, nlen, room;
    ntype = 32'(node_hdr[7:0]);
    nsub  = 32'(node_hdr[15:8]);
    nlen  = 32'(node_hdr[31:16]);
    room  = dp_size - node_base;
    flags &= ~(FL_FILE_NODE | FL_FILE_TERM);
    if (nlen < 4 || nlen > room) begin
      flags |= FL_PATH_ERR;
      return;
    end
    if (ntype == NODE_MEDIA && nsub == SUB_FILEPATH && loader_cnt == 0) begin
      if (((nlen - 4) & 1) != 0 || nlen == 4) begin
        flags |= FL_PATH_ERR;
        return;
      end
      flags |= FL_FILE_NODE;
    end
    if (ntype == NODE_END) begin
      if (nlen != 4 || (nsub != SUB_END_ALL && nsub != SUB_END_INST)) begin
        flags |= FL_PATH_ERR;
        return;
      end
      if (nsub == SUB_END_ALL) begin
        flags |= FL_END_ENTIRE;
        if (node_base + 4 != dp_size) begin
          flags |= FL_PATH_ERR;
          return;
        end
      end
    end
    node_left = nlen - 4;
  endtask

  task automatic path_step(logic [7:0] b);
    int unsigned nlen, idx;
    logic [15:0] ch;
    bit          extracting;
    if ((flags & FL_PATH_ERR) == 0) begin
      push_res(KIND_PATH, 16'(b), ST_OK, 1'b0);
      if (hdr_cnt > 0 || node_left == 0) begin
        if (hdr_cnt == 0) begin
          node_base = dp_off;
          node_hdr = '0;
          if (dp_size - dp_off < 4) flags |= FL_PATH_ERR;
        end
        if ((flags & FL_PATH_ERR) == 0) begin
          node_hdr[8*hdr_cnt +: 8] = b;
          hdr_cnt++;
          if (hdr_cnt == 4) begin
            hdr_cnt = 0;
            node_header_done();
          end
        end
      end else begin
        nlen = 32'(node_hdr[31:16]);
        idx = (nlen - 4) - node_left;
        extracting = (flags & FL_FILE_NODE) != 0 && (flags & FL_FILE_TERM) == 0;
        node_left--;
        if (extracting) begin
          if ((idx & 1) == 0) begin
            low_byte = b;
          end else begin
            ch = {b, low_byte};
            if (ch == 0) begin
              flags |= FL_FILE_TERM;
            end else if (loader_cnt < PATH_CAPACITY - 1) begin
              push_res(KIND_LOADER, ch, ST_OK, 1'b0);
              loader_cnt++;
            end
          end
          if (node_left == 0 && (flags & FL_FILE_TERM) == 0) flags |= FL_PATH_ERR;
        end
      end
    end
    dp_off++;
    if (dp_off >= dp_size) ph = PH_IDLE;
  endtask

  task automatic desc_step(int unsigned pos, logic [7:0] b);
    logic [15:0] ch;
    logic [15:0] fb[9];
    if (((pos - 6) & 1) == 0) begin
      low_byte = b;
      return;
    end
    ch = {b, low_byte};
    if (ch == 0) begin
      flags |= FL_TERM;
      if (name_cnt == 0) begin
        // Empty description: name the option after its number
        fb = '{16'h42, 16'h4F, 16'h4F, 16'h54, 16'h20, hex_digit(saved_num[15:12]),
               hex_digit(saved_num[11:8]), hex_digit(saved_num[7:4]),
               hex_digit(saved_num[3:0])};
        for (int i = 0; i < 9 && i < NAME_CAPACITY - 1; i++)
          push_res(KIND_DESC, fb[i], ST_OK, 1'b0);
      end
      ph = PH_PATH;
      dp_off = 0; hdr_cnt = 0; node_left = 0;
    end else if (name_cnt < NAME_CAPACITY - 1) begin
      push_res(KIND_DESC, (ch >= CHAR_LOW && ch <= CHAR_HIGH) ? ch : CHAR_QMARK,
               ST_OK, 1'b0);
      name_cnt++;
    end
  endtask

  function automatic status_e option_status();
    if ((flags & FL_OVER) != 0) return ST_BAD_SIZE;
    if (opt_pos < 8) return ST_TOO_SHORT;
    if (first_err != ST_OK) return first_err;
    if ((flags & FL_TERM) == 0) return ST_LOAD_ERR;
    if (dp_off < dp_size) return ST_BAD_SIZE;
    if ((flags & FL_PATH_ERR) != 0) return ST_LOAD_ERR;
    if ((flags & FL_END_ENTIRE) == 0) return ST_LOAD_ERR;
    return ST_OK;
  endfunction

  // Work out the results of one accepted byte
  task automatic parse_byte(logic [7:0] b, logic [15:0] num, logic last);
    int unsigned pos;
    if (opt_pos >= OPTION_MAX_BYTES) begin
      flags |= FL_OVER;
    end else begin
      pos = opt_pos;
      opt_pos++;
      if (ph == PH_HEADER) begin
        if (pos == 0) begin
          saved_num = num;
          if (b[0] == 1'b0) first_err = ST_INACTIVE;
        end else if (pos == 4) begin
          dp_size = 32'(b);
        end else if (pos == 5) begin
          dp_size |= 32'(b) << 8;
          if (first_err == ST_OK && (dp_size < 4 || dp_size > DEVICE_PATH_CAPACITY))
            first_err = ST_BAD_SIZE;
          ph = (first_err != ST_OK) ? PH_IDLE : PH_DESC;
        end
      end else if (ph == PH_DESC) begin
        desc_step(pos, b);
      end else if (ph == PH_PATH) begin
        path_step(b);
      end
    end
    if (last) begin
      push_res(KIND_STATUS, '0, option_status(), 1'b1);
      clear_option();
    end
  endtask

  // Offer one byte, hold it until it transfers, then predict
  task automatic send_byte(logic [7:0] b, logic [15:0] num, logic last);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    boot_number_i <= num;
    last_byte_i   <= last;
    do @(posedge clk_i); while (in_stall_o);
    parse_byte(b, num, last);
  endtask

  // Build one well-formed load option with random content, then maybe break it
  task automatic build_option(ref logic [7:0] opt[$]);
    logic [7:0] dp[$];
    int         nchar, blen, k;
    logic [15:0] ch;
    opt.delete();
    opt.push_back({7'($urandom_range(0, 127)), ($urandom_range(0, 9) != 0)});
    repeat (3) opt.push_back(8'($urandom));
    // Description: mostly short, sometimes empty or past the name capacity
    case ($urandom_range(0, 9))
      0, 1: nchar = 0;
      2: nchar = NAME_CAPACITY + $urandom_range(0, 3);
      default: nchar = $urandom_range(1, 6);
    endcase
    for (int i = 0; i < nchar; i++) begin
      case ($urandom_range(0, 2))
        0: ch = 16'($urandom_range(16'h20, 16'h7E));
        1: ch = 16'($urandom_range(1, 16'h1F));
        default: ch = 16'($urandom_range(16'h7F, 16'hFFFF));
      endcase
      opt.push_back(ch[7:0]);
      opt.push_back(ch[15:8]);
    end
    opt.push_back(8'h00);
    opt.push_back(8'h00);
    // Device path: some plain nodes, usually a file-path node, an end node
    repeat ($urandom_range(0, 2)) begin
      blen = $urandom_range(0, 4);
      dp.push_back(8'($urandom_range(1, 5)));
      dp.push_back(8'($urandom));
      dp.push_back(8'(blen + 4));
      dp.push_back(8'h00);
      repeat (blen) dp.push_back(8'($urandom));
    end
    if ($urandom_range(0, 3) != 0) begin
      k = $urandom_range(0, 5);
      blen = 2 * (k + 1) + (($urandom_range(0, 4) == 0) ? 2 : 0);
      dp.push_back(NODE_MEDIA);
      dp.push_back(SUB_FILEPATH);
      dp.push_back(8'(blen + 4));
      dp.push_back(8'h00);
      for (int i = 0; i < k; i++) begin
        ch = 16'($urandom_range(1, 16'hFFFF));
        dp.push_back(ch[7:0]);
        dp.push_back(ch[15:8]);
      end
      while (dp.size() % 2 != 0 || blen > 2 * k) begin
        dp.push_back(8'h00);
        blen--;
        if (blen == 2 * k) break;
      end
    end
    if ($urandom_range(0, 4) == 0) begin
      dp.push_back(NODE_END); dp.push_back(SUB_END_INST);
      dp.push_back(8'h04); dp.push_back(8'h00);
    end
    dp.push_back(NODE_END); dp.push_back(SUB_END_ALL);
    dp.push_back(8'h04); dp.push_back(8'h00);
    opt.insert(4, 8'(dp.size()));
    opt.insert(5, 8'(dp.size() >> 8));
    foreach (dp[i]) opt.push_back(dp[i]);
    // Break about a third of them
    case ($urandom_range(0, 11))
      0: opt[$urandom_range(6, opt.size() - 1)] = 8'($urandom);
      1: opt[$urandom_range(0, opt.size() - 1)] = 8'($urandom);
      2: repeat ($urandom_range(1, opt.size() - 1)) opt.delete(opt.size() - 1);
      3: repeat ($urandom_range(1, 3)) opt.push_back(8'($urandom));
      default: ;
    endcase
  endtask

  // Receiver: random stall bursts, one long hold-off, none at the end
  initial begin
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1;
      end else if (quiet) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
    end
  end

  // Compare each transfer with the oldest expected result
  always @(posedge clk_i) begin
    parse_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (parse_q.size() == 0) begin
        $display("%0t: unexpected result kind %0d value %h status %0d done %0d",
                 $time, kind_o, value_o, status_o, done_res_o);
        fail_cnt++;
      end else begin
        want = parse_q.pop_front();
        if (kind_o != want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind_o);
          fail_cnt++;
        end
        if (value_o != want.value) begin
          $display("%0t: value expected %h actual %h", $time, want.value, value_o);
          fail_cnt++;
        end
        if (status_o != want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          fail_cnt++;
        end
        if (done_res_o != want.done) begin
          $display("%0t: done expected %0d actual %0d", $time, want.done, done_res_o);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    dir_row_t    dir_tab[29];
    logic [7:0]  opt[$];
    logic [15:0] num;
    int          sent;
    int          n_opt;
    dir_tab = '{
      // one byte only: too short
      '{8'h01, 16'h0000, 1'b1, 1'b1, ST_TOO_SHORT},
      // active bit clear
      '{8'h00, 16'h1234, 1'b0, 1'b0, ST_OK}, '{8'h00, 16'h0, 1'b0, 1'b0, ST_OK},
      '{8'h00, 16'h0, 1'b0, 1'b0, ST_OK}, '{8'h00, 16'h0, 1'b0, 1'b0, ST_OK},
      '{8'h04, 16'h0, 1'b0, 1'b0, ST_OK}, '{8'h00, 16'h0, 1'b0, 1'b0, ST_OK},
      '{8'h00, 16'h0, 1'b0, 1'b0, ST_OK}, '{8'hFF, 16'h0, 1'b1, 1'b1, ST_INACTIVE},
      // device path size far above capacity
      '{8'hFF, 16'hFFFF, 1'b0, 1'b0, ST_OK}, '{8'hFF, 16'h0, 1'b0, 1'b0, ST_OK},
      '{8'hFF, 16'h0, 1'b0, 1'b0, ST_OK}, '{8'hFF, 16'h0, 1'b0, 1'b0, ST_OK},
      '{8'hFF, 16'h0, 1'b0, 1'b0, ST_OK}, '{8'hFF, 16'h0, 1'b0, 1'b0, ST_OK},
      '{8'h00, 16'h0, 1'b0, 1'b0, ST_OK}, '{8'h00, 16'h0, 1'b1, 1'b1, ST_BAD_SIZE},
      // empty description, lone end node: fallback name
      '{8'h01, 16'hFFFF, 1'b0, 1'b0, ST_OK}, '{8'h00, 16'h0, 1'b0, 1'b0, ST_OK},
      '{8'h00, 16'h0, 1'b0, 1'b0, ST_OK}, '{8'h00, 16'h0, 1'b0, 1'b0, ST_OK},
      '{8'h04, 16'h0, 1'b0, 1'b0, ST_OK}, '{8'h00, 16'h0, 1'b0, 1'b0, ST_OK},
      '{8'h00, 16'h0, 1'b0, 1'b0, ST_OK}, '{8'h00, 16'h0, 1'b0, 1'b0, ST_OK},
      '{8'h7F, 16'h0, 1'b0, 1'b0, ST_OK}, '{8'hFF, 16'h0, 1'b0, 1'b0, ST_OK},
      '{8'h04, 16'h0, 1'b0, 1'b0, ST_OK}, '{8'h00, 16'h0, 1'b1, 1'b0, ST_OK}
    };
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    boot_number_i = '0;
    last_byte_i = 1'b0;
    clear_option();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows; typed rows replace the predicted status by hand
    foreach (dir_tab[i]) begin
      send_byte(dir_tab[i].data, dir_tab[i].num, dir_tab[i].last);
      if (dir_tab[i].typed) begin
        void'(parse_q.pop_back());
        push_res(KIND_STATUS, '0, dir_tab[i].status, 1'b1);
      end
    end

    // Random options
    sent = 0;
    n_opt = 0;
    while (sent < 180) begin
      build_option(opt);
      num = 16'($urandom);
      n_opt++;
      if (n_opt == 4) hold_req = 1;
      if (sent > 130) quiet = 1;
      foreach (opt[i]) send_byte(opt[i], num, i == opt.size() - 1);
      sent += opt.size();
    end

    in_valid_i <= 1'b0;
    wait (parse_q.size() == 0);
    repeat (30) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("load_option_stream_parser_unit: match");
    end else begin
      $display("load_option_stream_parser_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lops_pkg.sv
rtl/load_option_stream_parser_unit.sv
tb/tb_load_option_stream_parser_unit.sv
